/* design/tkn_pkg.sv */
// shared types for the top-k nearest selector
// entry record, per-cell command group and sequencer states; no dependencies
package tkn_pkg;

  localparam int unsigned DIST_W = 32;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned KC_W   = 5;
  localparam int unsigned RANK_W = 4;

  // one kept candidate
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   id;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
    logic trim;
  } cell_cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

/* design/tkn_cell.sv */
// one slot of the sorted insertion chain
// depends on tkn_pkg for entry_t and cell_cmd_t
module tkn_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  tkn_pkg::cell_cmd_t           cmd,
  input  logic                         en,
  input  logic [tkn_pkg::DIST_W-1:0]   cand_distance,
  input  logic [tkn_pkg::ID_W-1:0]     cand_id,
  input  tkn_pkg::entry_t              left_entry,
  input  logic                         left_ins,
  input  tkn_pkg::entry_t              right_entry,
  output tkn_pkg::entry_t              entry,
  output logic                         ins
);
  import tkn_pkg::*;

  entry_t entry_next;
  logic   closer;

  // strict order: distance first, then id
  assign closer = (cand_distance < entry.distance) ||
                  ((cand_distance == entry.distance) && (cand_id < entry.id));

  // candidate lands here or further left
  assign ins = en && (!entry.valid || closer);

  // next slot content
  always_comb begin
    entry_next = entry;
    if (cmd.insert) begin
      if (!en) begin
        entry_next.valid = 1'b0;
      end else if (ins) begin
        if (left_ins) begin
          entry_next = left_entry;
        end else begin
          entry_next.valid    = 1'b1;
          entry_next.distance = cand_distance;
          entry_next.id       = cand_id;
        end
      end
    end else if (cmd.shift) begin
      entry_next = right_entry;
    end else if (cmd.trim) begin
      entry_next.valid = entry.valid && en;
    end
  end

  // slot register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.distance <= entry_next.distance;
    entry.id       <= entry_next.id;
  end

endmodule

/* design/top_k_nearest_selector.sv */
// top level of the top-k nearest selector: insertion chain, drain sequencer, output register
// depends on tkn_pkg and tkn_cell
//
// channel  | dir | fields (low bit up)
// s_*      | in  | tdata: distance[31:0], id[63:32]; tuser: kind (1 = finish)
// m_*      | out | tdata: rank[3:0], distance[35:4], id[67:36], zero[71:68];
//          |     | tuser: found; tlast: last
// cfg_*    | in  | cfg_wdata: keep_count
//
// a candidate is taken while idle; the whole chain compares it in parallel and shifts
// a finish drains one result per kept entry (at least one) as the chain shifts toward cell 0
// no input is taken while a finish drains; output stalls freeze the drain
// rst is synchronous; it empties the chain and sets keep_count to 1
module top_k_nearest_selector #(
  parameter int unsigned K_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // distance, id
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // rank, distance, id, zero fill
  output logic        m_tuser,   // found
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import tkn_pkg::*;

  localparam int unsigned NCELL = (K_MAX < 16) ? K_MAX : 16;

  state_t              state, state_next;
  logic [KC_W-1:0]     keep_count;
  logic [KC_W-1:0]     kc_eff;
  logic [RANK_W-1:0]   rank, rank_next;
  cell_cmd_t           cmd;
  logic                out_load;
  logic                m_tvalid_next;
  logic                in_xfer;
  logic                drain_last;

  entry_t              cells [NCELL];
  entry_t              left_e [NCELL];
  entry_t              right_e [NCELL];
  logic [NCELL-1:0]    ins;
  logic [NCELL-1:0]    left_ins;
  logic [NCELL-1:0]    en;
  logic [NCELL-1:0]    vld;

  assign in_xfer = s_tvalid && s_tready;

  // capacity in force: a config write trims against the new value
  assign kc_eff = cfg_we ? cfg_wdata : keep_count;

  // keep_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KC_W'(1);
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  // cell chain
  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      assign en[gi]  = kc_eff > KC_W'(gi);
      assign vld[gi] = cells[gi].valid;
      if (gi == 0) begin : g_first
        assign left_e[gi]   = '0;
        assign left_ins[gi] = 1'b0;
      end else begin : g_mid
        assign left_e[gi]   = cells[gi-1];
        assign left_ins[gi] = ins[gi-1];
      end
      if (gi == NCELL - 1) begin : g_end
        assign right_e[gi] = '0;
      end else begin : g_nxt
        assign right_e[gi] = cells[gi+1];
      end
      tkn_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .cmd           (cmd),
        .en            (en[gi]),
        .cand_distance (s_tdata[31:0]),
        .cand_id       (s_tdata[63:32]),
        .left_entry    (left_e[gi]),
        .left_ins      (left_ins[gi]),
        .right_entry   (right_e[gi]),
        .entry         (cells[gi]),
        .ins           (ins[gi])
      );
    end
  endgenerate

  // final result of a drain: empty chain or no successor
  assign drain_last = !cells[0].valid || !right_e[0].valid;
  assign out_load   = (state == ST_DRAIN) && (!m_tvalid || m_tready);

  // sequencer next state and controls
  always_comb begin
    state_next = state;
    rank_next  = rank;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.trim = cfg_we;
        if (in_xfer) begin
          if (s_tuser) begin
            state_next = ST_DRAIN;
            rank_next  = '0;
          end else begin
            cmd.insert = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          cmd.shift = 1'b1;
          rank_next = rank + RANK_W'(1);
          if (drain_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and rank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rank  <= '0;
    end else begin
      state <= state_next;
      rank  <= rank_next;
    end
  end

  // output register
  assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[3:0]   <= rank;
      m_tdata[35:4]  <= cells[0].valid ? cells[0].distance : '0;
      m_tdata[67:36] <= cells[0].valid ? cells[0].id : '0;
      m_tdata[71:68] <= '0;
      m_tuser        <= cells[0].valid;
      m_tlast        <= drain_last;
    end
  end

  // kept entries always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld & (vld + NCELL'(1))) == '0))
    else $error("kept entries do not form a prefix");

  // an empty result always closes its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty result without last");

  // a finish starts a drain
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tuser) |=> (state == ST_DRAIN))
    else $error("finish did not start a drain");

  // the chain is empty once a drain has ended
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && state_next == ST_IDLE) |=> (vld == '0))
    else $error("entries left after drain");

endmodule
